FILE: rtl/core/h264pfc_pkg.sv
// Package for the H.264 packet format classifier.
// Holds field widths, configuration register indexes and the result format codes.
// No dependencies.
package h264pfc_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned LenFieldW = 3;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 3;
  localparam int unsigned FmtW      = 2;
  localparam int unsigned LenW      = 32;
  localparam int unsigned PosW      = 3;

  localparam logic [CfgIdxW-1:0] CfgLengthFieldBytes = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgAvccConfigValid  = 1'b1;

  localparam logic [LenFieldW-1:0] LenFieldBytesReset = 3'd4;
  localparam logic [LenFieldW-1:0] LenFieldBytesMin   = 3'd1;
  localparam logic [LenFieldW-1:0] LenFieldBytesMax   = 3'd4;

  typedef enum logic [FmtW-1:0] {
    FMT_LENGTH_PREFIXED = 2'd0,
    FMT_START_CODE      = 2'd1,
    FMT_UNKNOWN         = 2'd2
  } fmt_e;

endpackage

FILE: rtl/core/h264pfc_if.sv
// Stream interfaces of the H.264 packet format classifier: packet bytes in, formats out.
// Depends on h264pfc_pkg.
interface h264pfc_byte_if;
  logic                           valid;
  logic                           ready;
  logic [h264pfc_pkg::ByteW-1:0]  byte_value;
  logic                           last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

interface h264pfc_fmt_if;
  logic                          valid;
  logic                          ready;
  logic [h264pfc_pkg::FmtW-1:0]  packet_format;

  modport source (output valid, output packet_format, input ready);
  modport sink (input valid, input packet_format, output ready);
endinterface

FILE: rtl/core/h264_packet_format_classifier_unit.sv
// Top level of the H.264 packet format classifier.
// Depends on h264pfc_pkg and the interfaces in h264pfc_if.sv.
//
//   channel   direction  transaction
//   byte_i    in         one packet byte and its last-byte mark
//   result_o  out        one packet format, given on the packet's last byte
//   cfg_*_i   in         register write, taken in the cycle the enable is high
//
// Each byte is taken into an input register and processed from there, so a new byte can
// be accepted every cycle while no last byte is held in that register. The format is
// written into the result register at the edge that ends the last byte's processing. A last
// byte waits in the input register only while the result register is full and not being
// drained. Reset restores the register defaults and clears all packet state; there is no
// clearing pass.
module h264_packet_format_classifier_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  h264pfc_byte_if.sink                           byte_i,
  h264pfc_fmt_if.source                          result_o,
  input  logic                                   cfg_we_i,
  input  logic [h264pfc_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [h264pfc_pkg::CfgDataW-1:0]       cfg_data_i
);

  logic [h264pfc_pkg::LenFieldW-1:0] len_bytes_q;
  logic                              avcc_q;

  logic                              s1_valid_q, s1_valid_d;
  logic [h264pfc_pkg::ByteW-1:0]     byte_q;
  logic                              last_q;

  logic [h264pfc_pkg::ByteW-1:0]     lead_q [3];
  logic [h264pfc_pkg::ByteW-1:0]     lead_d [3];
  logic [h264pfc_pkg::PosW-1:0]      pos_q, pos_d;
  logic [h264pfc_pkg::LenW-1:0]      accum_q, accum_d;
  logic [h264pfc_pkg::PosW-1:0]      taken_q, taken_d, taken_inc;
  logic [h264pfc_pkg::LenW-1:0]      left_q, left_d;
  logic                              in_pay_q, in_pay_d;
  logic                              seen_q, seen_d;
  logic                              broken_q, broken_d;

  logic                              out_valid_q, out_valid_d;
  h264pfc_pkg::fmt_e                 fmt_q, fmt_d;

  logic in_acc, out_free, s1_fire, size_ok, lead_zero, sc;

  assign out_free      = !out_valid_q || result_o.ready;
  assign s1_fire       = s1_valid_q && (!last_q || out_free);
  assign byte_i.ready  = !s1_valid_q || s1_fire;
  assign in_acc        = byte_i.valid && byte_i.ready;
  assign s1_valid_d    = in_acc || (s1_valid_q && !s1_fire);
  assign out_valid_d   = (s1_fire && last_q) || (out_valid_q && !result_o.ready);

  assign result_o.valid         = out_valid_q;
  assign result_o.packet_format = fmt_q;

  assign size_ok   = (len_bytes_q >= h264pfc_pkg::LenFieldBytesMin) &&
                     (len_bytes_q <= h264pfc_pkg::LenFieldBytesMax);
  assign lead_zero = (lead_q[0] == '0) && (lead_q[1] == '0);
  assign taken_inc = taken_q + 1'b1;

  always_comb begin
    case (pos_q)
      3'd0, 3'd1: sc = 1'b0;
      3'd2:       sc = lead_zero && (byte_q == 8'd1);
      3'd3:       sc = lead_zero && ((lead_q[2] == 8'd1) ||
                                     ((lead_q[2] == 8'd0) && (byte_q == 8'd1)));
      default:    sc = lead_zero && (lead_q[2] == 8'd1);
    endcase
  end

  always_comb begin
    lead_d   = lead_q;
    pos_d    = pos_q;
    accum_d  = accum_q;
    taken_d  = taken_q;
    left_d   = left_q;
    in_pay_d = in_pay_q;
    seen_d   = seen_q;
    broken_d = broken_q;
    fmt_d    = fmt_q;
    if (s1_fire) begin
      case (pos_q)
        3'd0: lead_d[0] = byte_q;
        3'd1: lead_d[1] = byte_q;
        3'd2: lead_d[2] = byte_q;
        3'd3: begin
          if (lead_zero && (lead_q[2] == 8'd0) && (byte_q == 8'd1)) begin
            lead_d[2] = 8'd1;
          end
        end
        default: ;
      endcase
      if (pos_q < 3'd4) begin
        pos_d = pos_q + 1'b1;
      end

      if (!broken_q) begin
        if (!size_ok) begin
          broken_d = 1'b1;
        end else if (in_pay_q) begin
          left_d = left_q - 1'b1;
          if (left_d == '0) begin
            in_pay_d = 1'b0;
          end
        end else begin
          accum_d = {accum_q[h264pfc_pkg::LenW-h264pfc_pkg::ByteW-1:0], byte_q};
          taken_d = taken_inc;
          if (taken_inc >= len_bytes_q) begin
            if (accum_d == '0) begin
              broken_d = 1'b1;
            end else begin
              left_d   = accum_d;
              in_pay_d = 1'b1;
              seen_d   = 1'b1;
            end
            accum_d = '0;
            taken_d = '0;
          end
        end
      end

      if (last_q) begin
        if (sc) begin
          fmt_d = h264pfc_pkg::FMT_START_CODE;
        end else if (avcc_q && size_ok && !broken_d && seen_d && !in_pay_d &&
                     (taken_d == '0)) begin
          fmt_d = h264pfc_pkg::FMT_LENGTH_PREFIXED;
        end else begin
          fmt_d = h264pfc_pkg::FMT_UNKNOWN;
        end
        lead_d[0] = '0;
        lead_d[1] = '0;
        lead_d[2] = '0;
        pos_d     = '0;
        accum_d   = '0;
        taken_d   = '0;
        left_d    = '0;
        in_pay_d  = 1'b0;
        seen_d    = 1'b0;
        broken_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_bytes_q <= h264pfc_pkg::LenFieldBytesReset;
      avcc_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        h264pfc_pkg::CfgLengthFieldBytes: len_bytes_q <= cfg_data_i;
        h264pfc_pkg::CfgAvccConfigValid:  avcc_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      lead_q[0]   <= '0;
      lead_q[1]   <= '0;
      lead_q[2]   <= '0;
      pos_q       <= '0;
      accum_q     <= '0;
      taken_q     <= '0;
      left_q      <= '0;
      in_pay_q    <= 1'b0;
      seen_q      <= 1'b0;
      broken_q    <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      lead_q      <= lead_d;
      pos_q       <= pos_d;
      accum_q     <= accum_d;
      taken_q     <= taken_d;
      left_q      <= left_d;
      in_pay_q    <= in_pay_d;
      seen_q      <= seen_d;
      broken_q    <= broken_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= byte_i.byte_value;
      last_q <= byte_i.last_byte;
    end
    fmt_q <= fmt_d;
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= 3'd4)
    else $error("byte position past saturation");

  a_payload_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_pay_q |-> (left_q != '0))
    else $error("payload flagged with nothing owed");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && last_q) |=> ((pos_q == '0) && !seen_q && !broken_q && !in_pay_q &&
                             (taken_q == '0)))
    else $error("packet state not cleared after last byte");

  a_lp_needs_avcc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (fmt_q == h264pfc_pkg::FMT_LENGTH_PREFIXED)) |-> avcc_q)
    else $error("length-prefixed result with check disabled");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_fire && last_q))
    else $error("result appeared without a last byte");

endmodule

FILE: tb/tb_h264_packet_format_classifier_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for h264_packet_format_classifier_unit: directed rows, then random
// packets under three handshake idling profiles, checked against an in-bench predictor.
// Depends on h264pfc_pkg, the interfaces in h264pfc_if.sv and the unit itself.
module tb_h264_packet_format_classifier_unit;
  import h264pfc_pkg::*;

  typedef struct {
    bit                   is_write;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
    logic [ByteW-1:0]     value;
    bit                   last;
    bit                   typed;
    fmt_e                 fmt;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  h264pfc_byte_if byte_if ();
  h264pfc_fmt_if  fmt_if ();

  h264_packet_format_classifier_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_i     (byte_if),
    .result_o   (fmt_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predictor copy of the registers and the packet state.
  logic [LenFieldW-1:0] pred_len_bytes = LenFieldBytesReset;
  bit                   pred_avcc_on   = 1'b0;
  logic [ByteW-1:0]     pk_lead [3]    = '{default: '0};
  logic [PosW-1:0]      pk_pos         = '0;
  logic [LenW-1:0]      pk_len_accum   = '0;
  logic [LenFieldW-1:0] pk_len_taken   = '0;
  logic [LenW-1:0]      pk_payload_left = '0;
  bit                   pk_in_payload  = 1'b0;
  bit                   pk_unit_seen   = 1'b0;
  bit                   pk_broken      = 1'b0;

  fmt_e             fmt_expected_q [$];
  logic [ByteW-1:0] pkt_q [$];
  dir_row_t         dir_rows [$];
  bit               item_typed = 1'b0;
  fmt_e             item_typed_fmt = FMT_UNKNOWN;
  int unsigned      src_idle_pct = 0;
  int unsigned      sink_idle_pct = 0;
  int unsigned      err_count = 0;
  int unsigned      n_bytes = 0;
  int unsigned      n_packets = 0;
  int unsigned      n_settings = 0;
  int unsigned      fmt_seen [4] = '{default: 0};
  logic [CfgDataW-1:0] seg_len [12] = '{3'd1, 3'd4, 3'd2, 3'd3, 3'd4, 3'd1,
                                        3'd0, 3'd2, 3'd5, 3'd3, 3'd7, 3'd4};

  always #2 clk_i = ~clk_i;

  initial begin
    byte_if.valid      = 1'b0;
    byte_if.byte_value = '0;
    byte_if.last_byte  = 1'b0;
    fmt_if.ready       = 1'b0;
  end

  function automatic bit classify_byte(input logic [ByteW-1:0] b, input bit last,
                                       output fmt_e fmt);
    bit lead_zero, sc, size_in_range;
    lead_zero     = pk_lead[0] == 8'h00 && pk_lead[1] == 8'h00;
    size_in_range = pred_len_bytes >= LenFieldBytesMin && pred_len_bytes <= LenFieldBytesMax;
    if (pk_pos < 2) begin
      sc = 1'b0;
    end else if (pk_pos == 2) begin
      sc = lead_zero && b == 8'h01;
    end else if (pk_pos == 3) begin
      sc = lead_zero && (pk_lead[2] == 8'h01 || (pk_lead[2] == 8'h00 && b == 8'h01));
    end else begin
      sc = lead_zero && pk_lead[2] == 8'h01;
    end

    if (pk_pos < 3) begin
      pk_lead[pk_pos[1:0]] = b;
    end else if (pk_pos == 3 && lead_zero && pk_lead[2] == 8'h00 && b == 8'h01) begin
      pk_lead[2] = 8'h01;
    end
    if (pk_pos < 4) pk_pos = pk_pos + 1'b1;

    if (!pk_broken) begin
      if (!size_in_range) begin
        pk_broken = 1'b1;
      end else if (pk_in_payload) begin
        pk_payload_left = pk_payload_left - 1'b1;
        if (pk_payload_left == '0) pk_in_payload = 1'b0;
      end else begin
        pk_len_accum = {pk_len_accum[LenW-9:0], b};
        pk_len_taken = pk_len_taken + 1'b1;
        if (pk_len_taken >= pred_len_bytes) begin
          if (pk_len_accum == '0) begin
            pk_broken = 1'b1;
          end else begin
            pk_payload_left = pk_len_accum;
            pk_in_payload   = 1'b1;
            pk_unit_seen    = 1'b1;
          end
          pk_len_accum = '0;
          pk_len_taken = '0;
        end
      end
    end

    fmt = FMT_UNKNOWN;
    if (!last) return 1'b0;
    if (sc) begin
      fmt = FMT_START_CODE;
    end else if (pred_avcc_on && size_in_range && !pk_broken && pk_unit_seen &&
                 !pk_in_payload && pk_len_taken == '0) begin
      fmt = FMT_LENGTH_PREFIXED;
    end
    pk_lead         = '{default: '0};
    pk_pos          = '0;
    pk_len_accum    = '0;
    pk_len_taken    = '0;
    pk_payload_left = '0;
    pk_in_payload   = 1'b0;
    pk_unit_seen    = 1'b0;
    pk_broken       = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [FmtW-1:0] got,
                                 input logic [FmtW-1:0] want);
    $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  always @(posedge clk_i) begin
    fmt_e predicted;
    fmt_e want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgLengthFieldBytes: pred_len_bytes = cfg_data_i;
          CfgAvccConfigValid:  pred_avcc_on   = cfg_data_i[0];
          default: ;
        endcase
      end
      if (byte_if.valid && byte_if.ready) begin
        n_bytes++;
        if (classify_byte(byte_if.byte_value, byte_if.last_byte, predicted)) begin
          fmt_expected_q.push_back(item_typed ? item_typed_fmt : predicted);
          n_packets++;
        end
      end
      if (fmt_if.valid && fmt_if.ready) begin
        if (fmt_expected_q.size() == 0) begin
          report_mismatch("format transaction with none expected", fmt_if.packet_format, 'x);
        end else begin
          want = fmt_expected_q.pop_front();
          fmt_seen[want]++;
          if (fmt_if.packet_format !== want)
            report_mismatch("packet_format mismatch", fmt_if.packet_format, want);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) fmt_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_byte(input logic [ByteW-1:0] b, input bit last, input bit typed,
                           input fmt_e fmt);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    byte_if.valid      <= 1'b1;
    byte_if.byte_value <= b;
    byte_if.last_byte  <= last;
    item_typed         <= typed;
    item_typed_fmt     <= fmt;
    do @(posedge clk_i); while (!byte_if.ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    byte_if.valid <= 1'b0;
    while (fmt_expected_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic row_byte(input logic [ByteW-1:0] b, input bit last, input bit typed,
                          input fmt_e fmt);
    dir_row_t r;
    r.is_write = 1'b0;
    r.idx      = '0;
    r.data     = '0;
    r.value    = b;
    r.last     = last;
    r.typed    = typed;
    r.fmt      = fmt;
    dir_rows.push_back(r);
  endtask

  task automatic row_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    dir_row_t r;
    r.is_write = 1'b1;
    r.idx      = idx;
    r.data     = data;
    r.value    = '0;
    r.last     = 1'b0;
    r.typed    = 1'b0;
    r.fmt      = FMT_UNKNOWN;
    dir_rows.push_back(r);
  endtask

  task automatic push_prefix(input int unsigned lf, input logic [LenW-1:0] len);
    for (int i = int'(lf) - 1; i >= 0; i--) pkt_q.push_back(len[8*i +: 8]);
  endtask

  task automatic build_packet();
    int unsigned lf, kind, units, len;
    pkt_q.delete();
    lf = (pred_len_bytes >= LenFieldBytesMin && pred_len_bytes <= LenFieldBytesMax) ?
         int'(pred_len_bytes) : $urandom_range(1, 4);
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      units = (kind < 55) ? $urandom_range(1, 3) : 1;
      repeat (units) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        push_prefix(lf, len);
        repeat (len) pkt_q.push_back(8'($urandom_range(0, 255)));
      end
      if (kind >= 55) begin
        case (kind % 4)
          0: begin
            push_prefix(lf, '0);
            repeat ($urandom_range(0, 2)) pkt_q.push_back(8'($urandom_range(0, 255)));
          end
          1: void'(pkt_q.pop_back());
          2: repeat ($urandom_range(1, lf)) pkt_q.push_back(8'($urandom_range(0, 255)));
          default: begin
            push_prefix(lf, {8'($urandom_range(128, 255)), 24'($urandom)});
            repeat ($urandom_range(1, 3)) pkt_q.push_back(8'($urandom_range(0, 255)));
          end
        endcase
      end
    end else if (kind < 85) begin
      pkt_q.push_back(8'h00);
      pkt_q.push_back(8'h00);
      if (kind % 2) pkt_q.push_back(8'h00);
      pkt_q.push_back(8'h01);
      repeat ($urandom_range(0, 5)) pkt_q.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 95) begin
      if (kind % 2) begin
        pkt_q.push_back(8'h00);
        pkt_q.push_back(8'h00);
        pkt_q.push_back(8'($urandom_range(0, 2)));
      end
      repeat ($urandom_range(1, 8)) pkt_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      pkt_q.push_back(8'h00);
      if (kind % 2) pkt_q.push_back(8'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int unsigned seg_items, cut;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset defaults: four-byte prefixes, length-prefixed check off.
    row_byte(8'h00, 0, 0, FMT_UNKNOWN);
    row_byte(8'h00, 0, 0, FMT_UNKNOWN);
    row_byte(8'h01, 1, 1, FMT_START_CODE);
    row_byte(8'h00, 0, 0, FMT_UNKNOWN);
    row_byte(8'h00, 0, 0, FMT_UNKNOWN);
    row_byte(8'h00, 0, 0, FMT_UNKNOWN);
    row_byte(8'h01, 1, 1, FMT_START_CODE);
    row_byte(8'h00, 1, 1, FMT_UNKNOWN);
    row_byte(8'h00, 0, 0, FMT_UNKNOWN);
    row_byte(8'h00, 1, 1, FMT_UNKNOWN);
    row_write(CfgLengthFieldBytes, 3'd1);
    row_byte(8'h01, 0, 0, FMT_UNKNOWN);
    row_byte(8'hFF, 1, 1, FMT_UNKNOWN);
    row_write(CfgAvccConfigValid, 3'd1);
    row_byte(8'h01, 0, 0, FMT_UNKNOWN);
    row_byte(8'hFF, 1, 1, FMT_LENGTH_PREFIXED);
    row_byte(8'h00, 1, 1, FMT_UNKNOWN);
    row_byte(8'h03, 0, 0, FMT_UNKNOWN);
    row_byte(8'h11, 1, 1, FMT_UNKNOWN);
    row_write(CfgLengthFieldBytes, 3'd4);
    row_byte(8'hFF, 0, 0, FMT_UNKNOWN);
    row_byte(8'hFF, 0, 0, FMT_UNKNOWN);
    row_byte(8'hFF, 0, 0, FMT_UNKNOWN);
    row_byte(8'hFF, 0, 0, FMT_UNKNOWN);
    row_byte(8'h80, 1, 1, FMT_UNKNOWN);
    row_write(CfgLengthFieldBytes, 3'd7);
    row_byte(8'h01, 0, 0, FMT_UNKNOWN);
    row_byte(8'hAA, 1, 1, FMT_UNKNOWN);
    row_write(CfgLengthFieldBytes, 3'd2);
    row_byte(8'h00, 0, 0, FMT_UNKNOWN);
    row_byte(8'h01, 0, 0, FMT_UNKNOWN);
    row_byte(8'h7F, 0, 0, FMT_UNKNOWN);
    row_byte(8'h00, 1, 1, FMT_UNKNOWN);
    row_byte(8'h00, 0, 0, FMT_UNKNOWN);
    row_write(CfgLengthFieldBytes, 3'd1);
    row_byte(8'h01, 0, 0, FMT_UNKNOWN);
    row_byte(8'hAA, 1, 0, FMT_UNKNOWN);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_write) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
        n_settings++;
      end else begin
        send_byte(dir_rows[i].value, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].fmt);
      end
    end

    for (int seg = 0; seg < 12; seg++) begin
      src_idle_pct  = (seg < 4) ? 27 : (seg < 8) ? 68 : 0;
      sink_idle_pct = (seg < 4) ? 68 : (seg < 8) ? 27 : 0;
      drain();
      write_reg(CfgLengthFieldBytes, seg_len[seg]);
      write_reg(CfgAvccConfigValid, (seg % 4 == 2) ? 3'd0 : 3'd1);
      n_settings++;
      seg_items = 0;
      while (seg_items < 84) begin
        build_packet();
        foreach (pkt_q[i]) send_byte(pkt_q[i], i == pkt_q.size() - 1, 1'b0, FMT_UNKNOWN);
        seg_items += pkt_q.size();
      end
      // Sometimes leave a packet open so the next register write lands mid-packet.
      if ($urandom_range(0, 2) == 0) begin
        build_packet();
        if (pkt_q.size() > 1) begin
          cut = $urandom_range(1, pkt_q.size() - 1);
          for (int i = 0; i < int'(cut); i++) send_byte(pkt_q[i], 1'b0, 1'b0, FMT_UNKNOWN);
        end
      end
    end

    drain();
    $display("Sent %0d bytes in %0d packets over %0d register settings and three idle profiles.",
             n_bytes, n_packets, n_settings);
    $display("Formats seen: %0d length-prefixed, %0d start-code, %0d unknown.",
             fmt_seen[FMT_LENGTH_PREFIXED], fmt_seen[FMT_START_CODE], fmt_seen[FMT_UNKNOWN]);
    if (err_count == 0) begin
      $display("[h264_packet_format_classifier_unit] OK");
    end else begin
      $display("[h264_packet_format_classifier_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d formats still expected.", fmt_expected_q.size());
    $display("[h264_packet_format_classifier_unit] ERROR");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/h264pfc_pkg.sv
rtl/core/h264pfc_if.sv
rtl/core/h264_packet_format_classifier_unit.sv
tb/tb_h264_packet_format_classifier_unit.sv
